/* hw/rtl/exlex_pkg.sv */
`timescale 1ns / 1ps

package exlex_pkg;

   // default width of the running byte position
   localparam int POSITION_BITS_DEFAULT = 16;

   // field widths of one result word
   localparam int KIND_BITS   = 5;
   localparam int START_BITS  = 16;
   localparam int LENGTH_BITS = 16;

   // result queue between the scanner and the output channel
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_UNARY  = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_ARROW  = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_SUB    = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_ADD    = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_MUL    = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_POW    = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_BAR    = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_DOT    = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_END    = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_BIND   = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_FUN    = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_SYMBOL = 5'd16;

   // characters with a role of their own
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   // keyword matcher progress
   localparam logic [2:0] KW_START   = 3'd0;
   localparam logic [2:0] KW_FIRST   = 3'd1;
   localparam logic [2:0] KW_MATCHED = 3'd3;
   localparam logic [2:0] KW_FAILED  = 3'd4;

   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_MINUS  = 3'd1,
      MODE_SEMI   = 3'd2,
      MODE_NUMBER = 3'd3,
      MODE_SYMBOL = 3'd4,
      MODE_ERROR  = 3'd5
   } scan_mode_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   token_kind;
      logic [START_BITS-1:0]  token_start;
      logic [LENGTH_BITS-1:0] token_length;
      logic                   unknown_char;
      logic                   text_done;
      logic                   last_of_run;
   } token_word_type;

   typedef struct packed {
      logic                 hit;
      logic [KIND_BITS-1:0] kind;
   } single_op_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   // letters of the keyword "fun"
   function automatic logic [7:0] keyword_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h66;
         2'd1:    c = 8'h75;
         2'd2:    c = 8'h6E;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // one-character operators reported at once
   function automatic single_op_type single_op(input logic [7:0] b);
      single_op_type r;
      r.hit  = 1'b1;
      r.kind = KIND_UNARY;
      unique case (b) inside
         8'h7E, 8'h40, 8'h21: r.kind = KIND_UNARY;
         8'h2B:               r.kind = KIND_ADD;
         8'h2A, 8'h2F, 8'h25: r.kind = KIND_MUL;
         8'h5E:               r.kind = KIND_POW;
         8'h7C:               r.kind = KIND_BAR;
         8'h28:               r.kind = KIND_LPAREN;
         8'h29:               r.kind = KIND_RPAREN;
         8'h2C:               r.kind = KIND_COMMA;
         8'h2E:               r.kind = KIND_DOT;
         8'h3D:               r.kind = KIND_BIND;
         default:             r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic token_word_type make_word(
      input logic [KIND_BITS-1:0]   kind,
      input logic [START_BITS-1:0]  start,
      input logic [LENGTH_BITS-1:0] length,
      input logic                   unknown,
      input logic                   done
   );
      token_word_type w;
      w.token_kind   = kind;
      w.token_start  = start;
      w.token_length = length;
      w.unknown_char = unknown;
      w.text_done    = done;
      w.last_of_run  = 1'b0;
      return w;
   endfunction

endpackage

/* hw/rtl/exlex_req_if.sv */
`timescale 1ns / 1ps

interface exlex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

/* hw/rtl/exlex_rsp_if.sv */
`timescale 1ns / 1ps

interface exlex_rsp_if;
   import exlex_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   token_kind;
   logic [START_BITS-1:0]  token_start;
   logic [LENGTH_BITS-1:0] token_length;
   logic                   unknown_char;
   logic                   text_done;
   logic                   last_of_run;

   modport source (
      output valid, output token_kind, output token_start, output token_length,
      output unknown_char, output text_done, output last_of_run, input ready
   );
   modport sink (
      input valid, input token_kind, input token_start, input token_length,
      input unknown_char, input text_done, input last_of_run, output ready
   );
endinterface

/* hw/rtl/expression_lexer_core.sv */
`timescale 1ns / 1ps

// channel   | dir | payload                                        | words per byte
// ----------+-----+------------------------------------------------+---------------
// req_bus   | in  | text_byte                                      | 1
// rsp_bus   | out | token_kind token_start token_length            | 0, 1 or 2
//           |     | unknown_char text_done last_of_run             |
//
// one text byte is taken per cycle while req_bus.ready is high; its tokens enter a
// four-word result queue at the same edge and leave from the queue head one word per cycle
// while rsp_bus.ready is high. req_bus.ready is high while the queue has room for two words,
// so a byte that flushes a pending token and reports its own word adds one more queued word,
// not an input stall unless the output side is stalled too.
// reset is synchronous: scanner idle, position zero, queue empty.

module expression_lexer_core #(
   parameter int POSITION_BITS = exlex_pkg::POSITION_BITS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   exlex_req_if.sink    req_bus,
   exlex_rsp_if.source  rsp_bus
);
   import exlex_pkg::*;

   localparam logic [QUEUE_CNT_BITS-1:0] COUNT_READY_MAX = QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
   localparam logic [QUEUE_CNT_BITS-1:0] COUNT_FULL      = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   // scanner state
   scan_mode_type            mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [START_BITS-1:0]    pend_start_ff, pend_start_in;
   logic [LENGTH_BITS-1:0]   pend_len_ff, pend_len_in;
   logic [2:0]               kw_ff, kw_in;

   // result queue
   token_word_type              queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   head_ff, tail_ff;
   logic [QUEUE_CNT_BITS-1:0]   count_ff;

   logic                           req_accept, rsp_accept;
   logic [7:0]                     b;
   logic [POSITION_BITS+START_BITS-1:0] pos_wide;
   logic [START_BITS-1:0]          pos16;
   logic [LENGTH_BITS-1:0]         len_inc;
   single_op_type                  op;
   logic                           fresh;
   logic                           a_valid, b_valid;
   token_word_type                 word_a, word_b;
   token_word_type                 first_word;
   logic                           push_one, push_two;
   logic [QUEUE_CNT_BITS-1:0]      push_num;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign rsp_accept = rsp_bus.valid && rsp_bus.ready;
   assign b          = req_bus.text_byte;

   // reported start is the low bits of the position, zero-extended when narrower
   assign pos_wide = {{START_BITS{1'b0}}, pos_ff};
   assign pos16    = pos_wide[START_BITS-1:0];
   assign len_inc  = (pend_len_ff == LENGTH_MAX) ? pend_len_ff : pend_len_ff + 1'b1;
   assign op       = single_op(b);

   // scan one byte: flush word first, then the word of the byte itself
   always_comb begin
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      pend_start_in = pend_start_ff;
      pend_len_in   = pend_len_ff;
      kw_in         = kw_ff;
      fresh         = 1'b1;
      a_valid       = 1'b0;
      b_valid       = 1'b0;
      word_a        = '0;
      word_b        = '0;

      unique case (mode_ff)
         MODE_ERROR: begin
            fresh = 1'b0;
            if (b == CHAR_NUL) begin
               a_valid = 1'b1;
               word_a  = make_word(KIND_UNARY, pos16, '0, 1'b0, 1'b1);
               mode_in = MODE_IDLE;
            end
         end
         MODE_MINUS: begin
            mode_in = MODE_IDLE;
            a_valid = 1'b1;
            if (b == CHAR_GT) begin
               word_a = make_word(KIND_ARROW, pend_start_ff, LENGTH_BITS'(2), 1'b0, 1'b0);
               fresh  = 1'b0;
            end else begin
               word_a = make_word(KIND_SUB, pend_start_ff, LENGTH_BITS'(1), 1'b0, 1'b0);
            end
         end
         MODE_SEMI: begin
            mode_in = MODE_IDLE;
            a_valid = 1'b1;
            if (b == CHAR_SEMI) begin
               word_a = make_word(KIND_END, pend_start_ff, LENGTH_BITS'(2), 1'b0, 1'b0);
               fresh  = 1'b0;
            end else begin
               word_a = make_word(KIND_SEMI, pend_start_ff, LENGTH_BITS'(1), 1'b0, 1'b0);
            end
         end
         MODE_NUMBER: begin
            if (is_digit(b)) begin
               pend_len_in = len_inc;
               fresh       = 1'b0;
            end else begin
               a_valid = 1'b1;
               word_a  = make_word(KIND_NUMBER, pend_start_ff, pend_len_ff, 1'b0, 1'b0);
               mode_in = MODE_IDLE;
            end
         end
         MODE_SYMBOL: begin
            if (is_alpha(b)) begin
               pend_len_in = len_inc;
               if ((kw_ff < KW_MATCHED) && (b == keyword_char(kw_ff[1:0]))) begin
                  kw_in = kw_ff + 1'b1;
               end else begin
                  kw_in = KW_FAILED;
               end
               fresh = 1'b0;
            end else begin
               a_valid = 1'b1;
               word_a  = make_word((kw_ff == KW_MATCHED) ? KIND_FUN : KIND_SYMBOL,
                                   pend_start_ff, pend_len_ff, 1'b0, 1'b0);
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // the byte as the start of something new
      if (fresh) begin
         if (b == CHAR_NUL) begin
            b_valid = 1'b1;
            word_b  = make_word(KIND_UNARY, pos16, '0, 1'b0, 1'b1);
         end else if (is_space(b)) begin
            b_valid = 1'b0;
         end else if (op.hit) begin
            b_valid = 1'b1;
            word_b  = make_word(op.kind, pos16, LENGTH_BITS'(1), 1'b0, 1'b0);
         end else if ((b == CHAR_MINUS) || (b == CHAR_SEMI)) begin
            mode_in       = (b == CHAR_MINUS) ? MODE_MINUS : MODE_SEMI;
            pend_start_in = pos16;
            pend_len_in   = LENGTH_BITS'(1);
         end else if (is_digit(b)) begin
            mode_in       = MODE_NUMBER;
            pend_start_in = pos16;
            pend_len_in   = LENGTH_BITS'(1);
         end else if (is_alpha(b)) begin
            mode_in       = MODE_SYMBOL;
            pend_start_in = pos16;
            pend_len_in   = LENGTH_BITS'(1);
            kw_in         = (b == keyword_char(2'd0)) ? KW_FIRST : KW_FAILED;
         end else begin
            b_valid = 1'b1;
            word_b  = make_word(KIND_UNARY, pos16, LENGTH_BITS'(1), 1'b1, 1'b0);
            mode_in = MODE_ERROR;
         end
      end

      // zero byte ends the text
      if (b == CHAR_NUL) begin
         pos_in  = '0;
         mode_in = MODE_IDLE;
      end else begin
         pos_in = pos_ff + 1'b1;
      end

      word_a.last_of_run = !b_valid;
      word_b.last_of_run = 1'b1;
   end

   // scanner state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         pos_ff        <= '0;
         pend_start_ff <= '0;
         pend_len_ff   <= '0;
         kw_ff         <= KW_START;
      end else if (req_accept) begin
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         pend_start_ff <= pend_start_in;
         pend_len_ff   <= pend_len_in;
         kw_ff         <= kw_in;
      end
   end

   // queue writes: one or two words at the tail
   assign push_one   = req_accept && (a_valid || b_valid);
   assign push_two   = req_accept && a_valid && b_valid;
   assign first_word = a_valid ? word_a : word_b;
   assign push_num   = QUEUE_CNT_BITS'(push_one) + QUEUE_CNT_BITS'(push_two);

   always_ff @(posedge clock) begin
      if (push_one) begin
         queue_ff[tail_ff] <= first_word;
      end
      if (push_two) begin
         queue_ff[tail_ff + 1'b1] <= word_b;
      end
   end

   // queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         tail_ff  <= tail_ff + QUEUE_PTR_BITS'(push_num);
         head_ff  <= head_ff + QUEUE_PTR_BITS'(rsp_accept);
         count_ff <= count_ff + push_num - QUEUE_CNT_BITS'(rsp_accept);
      end
   end

   assign req_bus.ready = (count_ff <= COUNT_READY_MAX);

   // output word from the queue head
   assign rsp_bus.valid        = (count_ff != '0);
   assign rsp_bus.token_kind   = queue_ff[head_ff].token_kind;
   assign rsp_bus.token_start  = queue_ff[head_ff].token_start;
   assign rsp_bus.token_length = queue_ff[head_ff].token_length;
   assign rsp_bus.unknown_char = queue_ff[head_ff].unknown_char;
   assign rsp_bus.text_done    = queue_ff[head_ff].text_done;
   assign rsp_bus.last_of_run  = queue_ff[head_ff].last_of_run;

   // checks
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_FULL)
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (b == CHAR_NUL)) |=> ((pos_ff == '0) && (mode_ff == MODE_IDLE)))
      else $error("zero byte did not restart the text");

   assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == MODE_NUMBER) || (mode_ff == MODE_SYMBOL)) |-> (pend_len_ff != '0))
      else $error("pending run with zero length");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !a_valid && !b_valid) |=> (count_ff == $past(count_ff)
         - QUEUE_CNT_BITS'($past(rsp_accept))))
      else $error("queue count moved without a pushed word");

endmodule
